// ===== src/mabl_pkg.sv =====
// Shared types, codes and widths for the blocked approximate pattern matcher.
package mabl_pkg;

    // Width of a block score; scores wrap at this width
    localparam int SCORE_W = 10;
    // Width of an effective pattern length (up to 64 bits times 16 blocks)
    localparam int LEN_W = 11;
    // Widths of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Defaults for the top-level parameters
    localparam int WORD_BITS_DEF = 64;
    localparam int BLOCKS_DEF = 4;
    localparam int SYMBOLS_DEF = 256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 1'b0,
        REG_MAX_ERRORS     = 1'b1
    } cfg_reg_t;

    // Request operation codes; the spare code is ignored
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_TEXT    = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    // Commands broadcast from the sequencer to the cells
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_CUT     = 2'd3
    } cell_cmd_t;

    // Horizontal delta carried from one cell to its neighbor
    typedef struct packed {
        logic pc;
        logic mc;
    } carry_t;

    // Broadcast control bundle for the row of cells
    typedef struct packed {
        cell_cmd_t            cmd;
        logic                 pc_cut;
        logic                 mc_cut;
        logic [SCORE_W-1:0]   cut_score;
        logic                 short_pat;
        logic [LEN_W-1:0]     pat_len;
    } cell_ctl_t;

endpackage

// ===== src/mabl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mabl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/mabl_cell.sv =====
// One block cell: holds the delta vectors and score of one pattern word.
module mabl_cell #(
    parameter int WORD_BITS = mabl_pkg::WORD_BITS_DEF,
    parameter int IDX = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mabl_pkg::cell_ctl_t            ctl,
    input  logic                           sel,
    input  logic [$clog2(WORD_BITS)-1:0]   shift,
    input  logic [WORD_BITS-1:0]           eq,
    input  mabl_pkg::carry_t               carry_in,
    output mabl_pkg::carry_t               carry_out,
    output logic [mabl_pkg::SCORE_W-1:0]   score
);
    import mabl_pkg::*;

    localparam int W = WORD_BITS;

    logic [W-1:0]       pv_reg, pv_next;
    logic [W-1:0]       mv_reg, mv_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    carry_t             carry_reg, carry_next;

    logic [W-1:0] y, x, u2, ph, mh, y2;

    // Column update of one word
    always_comb
    begin
        y  = eq | {{(W-1){1'b0}}, carry_in.mc};
        x  = (((y & pv_reg) + pv_reg) ^ pv_reg) | y;
        u2 = eq | mv_reg;
        ph = mv_reg | ~(x | pv_reg);
        mh = pv_reg & x;
        y2 = {ph[W-2:0], carry_in.pc};
    end

    // Select the next state by command
    always_comb
    begin
        pv_next    = pv_reg;
        mv_next    = mv_reg;
        score_next = score_reg;
        carry_next = carry_reg;
        case (ctl.cmd)
            CMD_RESTART:
            begin
                pv_next = '1;
                mv_next = '0;
                if (ctl.short_pat && (IDX == 0))
                begin
                    score_next = SCORE_W'(ctl.pat_len);
                end
                else
                begin
                    score_next = SCORE_W'((IDX + 1) * W);
                end
            end
            CMD_STEP:
            begin
                if (sel)
                begin
                    pv_next = {mh[W-2:0], 1'b0} | {{(W-1){1'b0}}, carry_in.mc} | ~(u2 | y2);
                    mv_next = y2 & u2;
                    carry_next.pc = ph[shift];
                    carry_next.mc = mh[shift];
                    score_next = score_reg + SCORE_W'(ph[shift]) - SCORE_W'(mh[shift]);
                end
            end
            CMD_CUT:
            begin
                if (sel)
                begin
                    pv_next = {{(W-1){1'b1}}, ctl.mc_cut};
                    mv_next = {{(W-1){1'b0}}, ctl.pc_cut};
                    score_next = ctl.cut_score;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= '1;
            mv_reg    <= '0;
            score_reg <= SCORE_W'((IDX + 1) * W);
            carry_reg <= '0;
        end
        else
        begin
            pv_reg    <= pv_next;
            mv_reg    <= mv_next;
            score_reg <= score_next;
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;
    assign score     = score_reg;

endmodule

// ===== src/myers_approx_match_blocked.sv =====
// Blocked bit-vector approximate matcher: sequencer, mask memory and row of block cells.
// Flow: a text request reads its mask word, then steps the cells from block 0 up to the active
// block (one cell per cycle); it then extends the active block by the cutoff, takes the score
// of a pattern that fits one word, or walks the active block down, and then finishes.
// Loads and restarts finish when accepted; one request is in work at a time, a held result stalls.
// Reset: vectors, scores and counters to start values, pattern length 1, mask memory kept.
module myers_approx_match_blocked #(
    parameter int WORD_BITS = mabl_pkg::WORD_BITS_DEF,
    parameter int BLOCKS    = mabl_pkg::BLOCKS_DEF,
    parameter int SYMBOLS   = mabl_pkg::SYMBOLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mabl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mabl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [7:0]                       symbol,
    input  logic [1:0]                       mask_block,
    input  logic [63:0]                      mask_word,
    input  logic [31:0]                      text_position,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [31:0]                      match_position,
    output logic [7:0]                       match_score,
    output logic [31:0]                      match_count
);
    import mabl_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int BW     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int RW     = $clog2(BLOCKS + 1);
    localparam int SW     = $clog2(W);
    localparam int DEPTH  = SYMBOLS * BLOCKS;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXLEN = W * BLOCKS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CELL = 6'b000100,
        S_CUT  = 6'b001000,
        S_WALK = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         plen_reg, plen_next;
    logic [7:0]         kerr_reg, kerr_next;
    logic [RW-1:0]      r_reg, r_next;
    logic [BW-1:0]      rd_reg, rd_next;
    logic [BW-1:0]      active_reg, active_next;
    logic [31:0]        matches_reg, matches_next;
    logic               hit_reg, hit_next;
    logic [7:0]         sym_reg, sym_next;
    logic               symok_reg, symok_next;
    logic [31:0]        pos_reg, pos_next;
    logic [SCORE_W-1:0] sc_reg, sc_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        opos_reg, opos_next;
    logic [7:0]         oscore_reg, oscore_next;
    logic [31:0]        ocount_reg, ocount_next;

    logic [LEN_W-1:0]   m_eff;
    logic [BW-1:0]      last;
    logic [BW-1:0]      b_start;
    logic [LEN_W-1:0]   rem1;
    logic               short_pat;
    logic [SCORE_W-1:0] k10, diw, dim, cut_score;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [W-1:0]       ram_rdata, eq;
    logic               sym_in_ok, blk_in_ok;

    cell_ctl_t          ctl;
    logic [BLOCKS-1:0]  sel;
    carry_t             carry [BLOCKS];
    logic [SCORE_W-1:0] blk_score [BLOCKS];
    logic [SW-1:0]      shift_vec [BLOCKS];

    // Derive pattern geometry from the configuration
    always_comb
    begin
        if (plen_reg == 9'd0)
        begin
            m_eff = LEN_W'(1);
        end
        else if (LEN_W'(plen_reg) > LEN_W'(MAXLEN))
        begin
            m_eff = LEN_W'(MAXLEN);
        end
        else
        begin
            m_eff = LEN_W'(plen_reg);
        end
        last    = '0;
        b_start = '0;
        for (int i = 1; i < BLOCKS; i++)
        begin
            if (m_eff > LEN_W'(i * W))
            begin
                last = BW'(i);
            end
            if (LEN_W'(kerr_reg) > LEN_W'(i * W))
            begin
                b_start = BW'(i);
            end
        end
        if (b_start > last)
        begin
            b_start = last;
        end
        rem1      = (m_eff - LEN_W'(1)) - LEN_W'(last) * LEN_W'(W);
        short_pat = (m_eff <= LEN_W'(W));
        k10       = SCORE_W'(kerr_reg);
        diw       = SCORE_W'(W) + k10;
        dim       = SCORE_W'(rem1) + SCORE_W'(1) + k10;
        cut_score = ((RW'(last) == r_reg) ? dim : diw) - SCORE_W'(1);
    end

    // Check request fields against the store bounds
    assign sym_in_ok = (32'(symbol) < 32'(SYMBOLS));
    assign blk_in_ok = (32'(mask_block) < 32'(BLOCKS));
    assign ram_we    = (state_reg == S_IDLE) && in_valid && (operation == OP_LOAD)
                       && sym_in_ok && blk_in_ok;
    assign ram_waddr = AW'(32'(symbol) * 32'(BLOCKS) + 32'(mask_block));
    assign ram_raddr = AW'(32'(sym_reg) * 32'(BLOCKS)
                       + ((state_reg == S_READ) ? 32'd0 : 32'(r_reg) + 32'd1));
    assign eq        = symok_reg ? ram_rdata : '0;

    mabl_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mask_word[W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Build the row of block cells
    for (genvar g = 0; g < BLOCKS; g++)
    begin : g_cell
        carry_t cin;
        if (g == 0)
        begin : g_first
            assign cin = '0;
        end
        else
        begin : g_rest
            assign cin = carry[g-1];
        end
        assign sel[g]       = (r_reg == RW'(g));
        assign shift_vec[g] = (BW'(g) == last) ? SW'(rem1) : SW'(W - 1);

        mabl_cell #(
            .WORD_BITS (W),
            .IDX       (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sel       (sel[g]),
            .shift     (shift_vec[g]),
            .eq        (eq),
            .carry_in  (cin),
            .carry_out (carry[g]),
            .score     (blk_score[g])
        );
    end

    // Sequence one request through the cells and the cutoff
    always_comb
    begin
        state_next     = state_reg;
        plen_next      = plen_reg;
        kerr_next      = kerr_reg;
        r_next         = r_reg;
        rd_next        = rd_reg;
        active_next    = active_reg;
        matches_next   = matches_reg;
        hit_next       = hit_reg;
        sym_next       = sym_reg;
        symok_next     = symok_reg;
        pos_next       = pos_reg;
        sc_next        = sc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        opos_next      = opos_reg;
        oscore_next    = oscore_reg;
        ocount_next    = ocount_reg;

        ctl.cmd       = CMD_NONE;
        ctl.pc_cut    = carry[rd_reg].pc;
        ctl.mc_cut    = carry[rd_reg].mc;
        ctl.cut_score = cut_score;
        ctl.short_pat = short_pat;
        ctl.pat_len   = m_eff;

        // Take configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: plen_next = cfg_data;
                REG_MAX_ERRORS:     kerr_next = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        OP_RESTART:
                        begin
                            ctl.cmd      = CMD_RESTART;
                            active_next  = b_start;
                            matches_next = '0;
                        end
                        OP_TEXT:
                        begin
                            sym_next   = symbol;
                            symok_next = sym_in_ok;
                            pos_next   = text_position;
                            r_next     = '0;
                            if (short_pat)
                            begin
                                rd_next = '0;
                            end
                            else if (active_reg > last)
                            begin
                                rd_next = last;
                            end
                            else
                            begin
                                rd_next = active_reg;
                            end
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CELL;
            end
            S_CELL:
            begin
                ctl.cmd = CMD_STEP;
                sc_next = blk_score[r_reg[BW-1:0]];
                r_next  = r_reg + RW'(1);
                if (r_reg == RW'(rd_reg))
                begin
                    state_next = S_CUT;
                end
            end
            S_CUT:
            begin
                if (short_pat)
                begin
                    sc_next    = blk_score[0];
                    hit_next   = (blk_score[0] <= k10);
                    state_next = S_FIN;
                end
                else if ((r_reg <= RW'(last)) && (sc_reg == k10)
                         && (eq[0] || carry[rd_reg].mc))
                begin
                    ctl.cmd     = CMD_CUT;
                    active_next = r_reg[BW-1:0];
                    sc_next     = cut_score;
                    hit_next    = (r_reg == RW'(last)) && (cut_score <= k10);
                    state_next  = S_FIN;
                end
                else
                begin
                    if ((rd_reg == last) && (blk_score[rd_reg] > dim) && (rd_reg != '0))
                    begin
                        rd_next = rd_reg - BW'(1);
                    end
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if ((rd_reg < last) && (blk_score[rd_reg] > diw) && (rd_reg != '0))
                begin
                    rd_next = rd_reg - BW'(1);
                end
                else
                begin
                    active_next = rd_reg;
                    sc_next     = blk_score[rd_reg];
                    hit_next    = (rd_reg == last) && (blk_score[rd_reg] <= k10);
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!hit_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    matches_next   = matches_reg + 32'd1;
                    out_valid_next = 1'b1;
                    opos_next      = pos_reg;
                    oscore_next    = sc_reg[7:0];
                    ocount_next    = matches_reg + 32'd1;
                    hit_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            plen_reg      <= 9'd1;
            kerr_reg      <= '0;
            r_reg         <= '0;
            rd_reg        <= '0;
            active_reg    <= '0;
            matches_reg   <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            kerr_reg      <= kerr_next;
            r_reg         <= r_next;
            rd_reg        <= rd_next;
            active_reg    <= active_next;
            matches_reg   <= matches_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        symok_reg  <= symok_next;
        pos_reg    <= pos_next;
        sc_reg     <= sc_next;
        opos_reg   <= opos_next;
        oscore_reg <= oscore_next;
        ocount_reg <= ocount_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign match_position = opos_reg;
    assign match_score    = oscore_reg;
    assign match_count    = ocount_reg;

endmodule
